>>> sv/dicf_pkg.sv
// ----------------------------------------------------------------------------
// dicf_pkg: shared types and constants of the double integrator
// Fixed data format, coefficient format, request and register codes, the
// sequencer states and the saturation helpers used by the datapath.
// ----------------------------------------------------------------------------
package dicf_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int COEF_FRAC = 30;
    localparam int FRIC_W    = 31;
    localparam int ACC_W     = DATA_W + 2;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int IN_W      = 3 * DATA_W;
    localparam int OUT_W     = 2 * DATA_W;
    localparam int FLAG_W    = 2;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    localparam data_t DMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam data_t DMIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam data_t COEF_DECAY_RST = 32'sd1073741824;
    localparam data_t COEF_GAIN_RST  = 32'sd536871;
    localparam data_t COEF_STOP_RST  = 32'sd131072000;
    localparam logic [FRIC_W-1:0] HALF_STEP_RST = 31'd536871;

    typedef enum logic [REQ_W-1:0] {
        REQ_INTEGRATE,
        REQ_INTEGRATE_BACKUP,
        REQ_REDO,
        REQ_LOAD
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_DECAY,
        CFG_COEF_GAIN,
        CFG_COEF_STOP,
        CFG_HALF_STEP,
        CFG_STATIC_ACCEL,
        CFG_KINETIC_ACCEL
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STOP_MUL,
        ST_STOP_WAIT,
        ST_STOP_NEG,
        ST_STOP_SUB,
        ST_BAND,
        ST_ADV_SUM,
        ST_ADV_GAIN,
        ST_ADV_DECAY,
        ST_ADV_VEL,
        ST_ADV_MID,
        ST_ADV_HMUL,
        ST_ADV_HWAIT,
        ST_ADV_POS,
        ST_DONE
    } fsm_state_t;

    typedef struct packed {
        logic  issue;
        logic  frac_coef;
        data_t a;
        data_t b;
    } mul_req_t;

    typedef struct packed {
        logic              ovf;
        logic              neg;
        logic [DATA_W-1:0] mag;
    } mul_res_t;

    function automatic acc_t sx(input data_t d);
        return ACC_W'(d);
    endfunction

    // Clamp a widened sum to the data range; the top bit flags a clip.
    function automatic logic [DATA_W:0] sat_result(input logic signed [ACC_W:0] x);
        logic [DATA_W:0] r;
        if ((&x[ACC_W:DATA_W-1]) || !(|x[ACC_W:DATA_W-1])) begin
            r = {1'b0, x[DATA_W-1:0]};
        end
        else if (x[ACC_W]) begin
            r = {1'b1, DMIN};
        end
        else begin
            r = {1'b1, DMAX};
        end
        return r;
    endfunction

    function automatic acc_t mul_value(input mul_res_t res);
        acc_t m;
        acc_t r;
        m = ACC_W'(res.mag);
        if (res.ovf) begin
            r = res.neg ? sx(DMIN) : sx(DMAX);
        end
        else begin
            r = res.neg ? -m : m;
        end
        return r;
    endfunction

endpackage

>>> sv/dicf_mul.sv
// ----------------------------------------------------------------------------
// dicf_mul: shared fixed-point multiplier
// Two stages: a registered 32x32 signed product, then rounding half away
// from zero, the fractional shift and the overflow test against the range.
// ----------------------------------------------------------------------------
module dicf_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  dicf_pkg::mul_req_t req,
    output dicf_pkg::mul_res_t res
);
    import dicf_pkg::*;

    localparam int PROD_W = 2 * DATA_W;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     frac_coef_reg;
    logic                     round_en_reg;
    mul_res_t                 res_reg;

    logic [PROD_W-1:0] prod_mag;
    logic [PROD_W-1:0] prod_rnd;
    logic [PROD_W-1:0] shifted;
    logic              neg;
    logic              ovf;

    always_comb
    begin
        neg      = prod_reg[PROD_W-1];
        prod_mag = neg ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        if (frac_coef_reg)
        begin
            prod_rnd = prod_mag + (PROD_W'(1) << (COEF_FRAC - 1));
            shifted  = prod_rnd >> COEF_FRAC;
        end
        else
        begin
            prod_rnd = prod_mag + (PROD_W'(1) << (FRAC_BITS - 1));
            shifted  = prod_rnd >> FRAC_BITS;
        end
        // The negative limit is one step larger than the positive one.
        ovf = (|shifted[PROD_W-1:DATA_W]) ||
              (shifted[DATA_W-1] && !(neg && !(|shifted[DATA_W-2:0])));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_en_reg <= 1'b0;
        end
        else
        begin
            round_en_reg <= req.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.issue)
        begin
            prod_reg      <= $signed(req.a) * $signed(req.b);
            frac_coef_reg <= req.frac_coef;
        end
        if (round_en_reg)
        begin
            res_reg.ovf <= ovf;
            res_reg.neg <= neg;
            res_reg.mag <= shifted[DATA_W-1:0];
        end
    end

    assign res = res_reg;

endmodule

>>> sv/double_integrator_coulomb_friction.sv
// ----------------------------------------------------------------------------
// double_integrator_coulomb_friction: damped double integrator with
// stick-slip friction
// Each input word carries a request kind on s_tuser and an applied
// acceleration plus load values on s_tdata. The block keeps velocity,
// position and the previous effective acceleration, and returns one output
// word per request with the new velocity and position on m_tdata and the
// stuck and saturated flags on m_tuser. Coefficients come in through the
// cfg_we / cfg_index / cfg_data write port; the user must write them only
// while the block is idle, as the block itself does not enforce this. One
// multiplier and one saturating adder are shared under a sequencer, so
// s_tready is high only while idle. A slipping integrate runs all four
// multiplies, a stuck one only the stop multiply, a redo three and a load
// none; each passes the multiplier's registered product and registered
// rounding stage before its result is used.
// A finished word waits in the output register while m_tready is low. The
// block still takes one more request, holds it in its final step and
// accepts nothing new until the waiting word leaves.
// Reset clears the state and backups to zero and loads the default
// coefficients with zero friction.
// ----------------------------------------------------------------------------
module double_integrator_coulomb_friction (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // accel, load_position, load_velocity
    input  logic [dicf_pkg::IN_W-1:0]         s_tdata,
    // req_type
    input  logic [dicf_pkg::REQ_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // velocity, position
    output logic [dicf_pkg::OUT_W-1:0]        m_tdata,
    // stuck, saturated
    output logic [dicf_pkg::FLAG_W-1:0]       m_tuser,
    input  logic                              cfg_we,
    input  logic [dicf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dicf_pkg::DATA_W-1:0]       cfg_data
);
    import dicf_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    data_t             coef_decay_reg;
    data_t             coef_gain_reg;
    data_t             coef_stop_reg;
    logic [FRIC_W-1:0] half_step_reg;
    logic [FRIC_W-1:0] static_accel_reg;
    logic [FRIC_W-1:0] kinetic_accel_reg;

    data_t vel_now_reg;
    data_t pos_now_reg;
    data_t prev_accel_reg;
    data_t vel_bk_reg;
    data_t pos_bk_reg;
    data_t acc_bk_reg;
    logic  out_valid_reg;
    logic  out_stuck_reg;
    logic  out_sat_reg;

    data_t u_reg;
    data_t v0_reg;
    data_t p0_reg;
    data_t a0_reg;
    data_t t_reg;
    data_t eff_reg;
    data_t res_vel_reg;
    data_t res_pos_reg;
    data_t res_acc_reg;
    logic  stuck_reg;
    logic  clip_reg;

    req_t  req_in;
    data_t in_accel;
    data_t in_pos;
    data_t in_vel;
    logic  accept;
    logic  done_fire;

    mul_req_t mreq;
    mul_res_t mres;
    acc_t     mval;
    logic     mul_used;

    acc_t                alu_a;
    acc_t                alu_b;
    logic                alu_sub;
    logic signed [ACC_W:0] alu_sum;
    logic [DATA_W:0]     alu_out;
    data_t               alu_y;
    logic                alu_clip;

    acc_t stop_x;
    acc_t u_x;
    acc_t s_x;
    logic above_low;
    logic below_high;

    assign req_in   = req_t'(s_tuser);
    assign in_accel = s_tdata[DATA_W-1:0];
    assign in_pos   = s_tdata[2*DATA_W-1:DATA_W];
    assign in_vel   = s_tdata[3*DATA_W-1:2*DATA_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign done_fire = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {pos_now_reg, vel_now_reg};
    assign m_tuser  = {out_sat_reg, out_stuck_reg};

    dicf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .res   (mres)
    );

    assign mval = mul_value(mres);

    // Exact tests against the static band, wide enough that nothing clips.
    assign stop_x     = sx(t_reg);
    assign u_x        = sx(u_reg);
    assign s_x        = ACC_W'(static_accel_reg);
    assign above_low  = stop_x > (u_x - s_x);
    assign below_high = stop_x < (u_x + s_x);

    assign alu_sum  = alu_sub ? ((ACC_W+1)'(alu_a) - (ACC_W+1)'(alu_b))
                              : ((ACC_W+1)'(alu_a) + (ACC_W+1)'(alu_b));
    assign alu_out  = sat_result(alu_sum);
    assign alu_clip = alu_out[DATA_W] || (mul_used && mres.ovf);
    assign alu_y    = alu_out[DATA_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        mreq       = '0;
        alu_a      = '0;
        alu_b      = '0;
        alu_sub    = 1'b0;
        mul_used   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (req_in)
                        REQ_INTEGRATE, REQ_INTEGRATE_BACKUP: state_next = ST_STOP_MUL;
                        REQ_REDO:                            state_next = ST_ADV_SUM;
                        REQ_LOAD:                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_STOP_MUL:
            begin
                mreq.issue = 1'b1;
                mreq.a     = coef_stop_reg;
                mreq.b     = v0_reg;
                state_next = ST_STOP_WAIT;
            end
            ST_STOP_WAIT:
            begin
                state_next = ST_STOP_NEG;
            end
            ST_STOP_NEG:
            begin
                alu_b      = mval;
                alu_sub    = 1'b1;
                mul_used   = 1'b1;
                state_next = ST_STOP_SUB;
            end
            ST_STOP_SUB:
            begin
                alu_a      = sx(t_reg);
                alu_b      = sx(a0_reg);
                alu_sub    = 1'b1;
                state_next = ST_BAND;
            end
            ST_BAND:
            begin
                alu_a   = u_x;
                alu_b   = ACC_W'(kinetic_accel_reg);
                alu_sub = !above_low;
                if (above_low && below_high)
                begin
                    alu_a      = '0;
                    alu_b      = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_ADV_SUM;
                end
            end
            ST_ADV_SUM:
            begin
                alu_a          = sx(eff_reg);
                alu_b          = sx(a0_reg);
                mreq.issue     = 1'b1;
                mreq.frac_coef = 1'b1;
                mreq.a         = coef_decay_reg;
                mreq.b         = v0_reg;
                state_next     = ST_ADV_GAIN;
            end
            ST_ADV_GAIN:
            begin
                mreq.issue     = 1'b1;
                mreq.frac_coef = 1'b1;
                mreq.a         = coef_gain_reg;
                mreq.b         = t_reg;
                state_next     = ST_ADV_DECAY;
            end
            ST_ADV_DECAY:
            begin
                alu_b      = mval;
                mul_used   = 1'b1;
                state_next = ST_ADV_VEL;
            end
            ST_ADV_VEL:
            begin
                alu_a      = sx(t_reg);
                alu_b      = mval;
                mul_used   = 1'b1;
                state_next = ST_ADV_MID;
            end
            ST_ADV_MID:
            begin
                alu_a      = sx(res_vel_reg);
                alu_b      = sx(v0_reg);
                state_next = ST_ADV_HMUL;
            end
            ST_ADV_HMUL:
            begin
                mreq.issue     = 1'b1;
                mreq.frac_coef = 1'b1;
                mreq.a         = DATA_W'(half_step_reg);
                mreq.b         = t_reg;
                state_next     = ST_ADV_HWAIT;
            end
            ST_ADV_HWAIT:
            begin
                state_next = ST_ADV_POS;
            end
            ST_ADV_POS:
            begin
                alu_a      = sx(p0_reg);
                alu_b      = mval;
                mul_used   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (done_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            coef_decay_reg    <= COEF_DECAY_RST;
            coef_gain_reg     <= COEF_GAIN_RST;
            coef_stop_reg     <= COEF_STOP_RST;
            half_step_reg     <= HALF_STEP_RST;
            static_accel_reg  <= '0;
            kinetic_accel_reg <= '0;
            vel_now_reg       <= '0;
            pos_now_reg       <= '0;
            prev_accel_reg    <= '0;
            vel_bk_reg        <= '0;
            pos_bk_reg        <= '0;
            acc_bk_reg        <= '0;
            out_valid_reg     <= 1'b0;
            out_stuck_reg     <= 1'b0;
            out_sat_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_COEF_DECAY:    coef_decay_reg    <= cfg_data;
                    CFG_COEF_GAIN:     coef_gain_reg     <= cfg_data;
                    CFG_COEF_STOP:     coef_stop_reg     <= cfg_data;
                    CFG_HALF_STEP:     half_step_reg     <= cfg_data[FRIC_W-1:0];
                    CFG_STATIC_ACCEL:  static_accel_reg  <= cfg_data[FRIC_W-1:0];
                    CFG_KINETIC_ACCEL: kinetic_accel_reg <= cfg_data[FRIC_W-1:0];
                    default:           ;
                endcase
            end
            if (accept && (req_in == REQ_INTEGRATE_BACKUP))
            begin
                vel_bk_reg <= vel_now_reg;
                pos_bk_reg <= pos_now_reg;
                acc_bk_reg <= prev_accel_reg;
            end
            if (done_fire)
            begin
                vel_now_reg    <= res_vel_reg;
                pos_now_reg    <= res_pos_reg;
                prev_accel_reg <= res_acc_reg;
                out_stuck_reg  <= stuck_reg;
                out_sat_reg    <= clip_reg;
                out_valid_reg  <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            u_reg     <= in_accel;
            stuck_reg <= 1'b0;
            clip_reg  <= 1'b0;
            if (req_in == REQ_REDO)
            begin
                v0_reg      <= vel_bk_reg;
                p0_reg      <= pos_bk_reg;
                a0_reg      <= acc_bk_reg;
                eff_reg     <= in_accel;
                res_acc_reg <= in_accel;
            end
            else
            begin
                v0_reg <= vel_now_reg;
                p0_reg <= pos_now_reg;
                a0_reg <= prev_accel_reg;
            end
            if (req_in == REQ_LOAD)
            begin
                res_vel_reg <= in_vel;
                res_pos_reg <= in_pos;
                res_acc_reg <= in_accel;
            end
        end
        else if (state_reg != ST_IDLE)
        begin
            clip_reg <= clip_reg | alu_clip;
        end
        unique case (state_reg)
            ST_STOP_NEG, ST_STOP_SUB, ST_ADV_SUM, ST_ADV_DECAY, ST_ADV_MID:
            begin
                t_reg <= alu_y;
            end
            ST_BAND:
            begin
                if (above_low && below_high)
                begin
                    stuck_reg   <= 1'b1;
                    res_vel_reg <= '0;
                    res_pos_reg <= p0_reg;
                    res_acc_reg <= t_reg;
                end
                else
                begin
                    eff_reg     <= alu_y;
                    res_acc_reg <= alu_y;
                end
            end
            ST_ADV_VEL:
            begin
                res_vel_reg <= alu_y;
            end
            ST_ADV_POS:
            begin
                res_pos_reg <= alu_y;
            end
            default:
            begin
            end
        endcase
    end

endmodule

>>> sv/dicf_checker.sv
// ----------------------------------------------------------------------------
// dicf_checker: port-level checks of the double integrator
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module dicf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [dicf_pkg::OUT_W-1:0]    m_tdata,
    input logic [dicf_pkg::FLAG_W-1:0]   m_tuser
);
    import dicf_pkg::*;

    // A stalled output word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // One request at a time: the block is busy right after it takes a word.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again without a busy cycle");

    // A stuck mass reports zero velocity.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[DATA_W-1:0] == '0)
        else $error("stuck word with nonzero velocity");

    // A new word only ever appears at the end of a busy stretch.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("output word appeared while idle");

endmodule

bind double_integrator_coulomb_friction dicf_checker u_dicf_checker (.*);
